// ----- sv/radix_digit_converter_core_defines.svh -----
// Assertion macros used by the radix digit converter checker.
`ifndef RADIX_DIGIT_CONVERTER_CORE_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radix digit converter check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radix digit converter check failed");

`endif

// ----- sv/rdc_pkg.sv -----
// Types, constants and microcode table of the radix digit converter.
`default_nettype none

package rdc_pkg;

  localparam logic [6:0] CHAR_ZERO = 7'd48;
  localparam logic [6:0] CHAR_A = 7'd65;
  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic REG_RADIX = 1'b0;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_TEST = 3'd1;
  localparam step_t STEP_DIV = 3'd2;
  localparam step_t STEP_PUSH = 3'd3;
  localparam step_t STEP_POP = 3'd4;
  localparam step_t STEP_EMIT = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLRDIV,
    OP_DIV,
    OP_PUSH,
    OP_POP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_START,
    JMP_Q_ZERO,
    JMP_BITS_LEFT,
    JMP_EMPTY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    begin
      case (s)
        STEP_IDLE: w = '{op: OP_LOAD, cond: JMP_NO_START, target: STEP_IDLE};
        STEP_TEST: w = '{op: OP_CLRDIV, cond: JMP_Q_ZERO, target: STEP_POP};
        STEP_DIV: w = '{op: OP_DIV, cond: JMP_BITS_LEFT, target: STEP_DIV};
        STEP_PUSH: w = '{op: OP_PUSH, cond: JMP_ALWAYS, target: STEP_TEST};
        STEP_POP: w = '{op: OP_POP, cond: JMP_EMPTY, target: STEP_IDLE};
        STEP_EMIT: w = '{op: OP_EMIT, cond: JMP_ALWAYS, target: STEP_POP};
        default: w = '{op: OP_NOP, cond: JMP_ALWAYS, target: STEP_IDLE};
      endcase
      return w;
    end
  endfunction

  function automatic logic [6:0] digit_ascii(logic [3:0] d);
    begin
      if (d < 4'd10) begin
        return CHAR_ZERO + {3'b000, d};
      end else begin
        return CHAR_A + {3'b000, d - 4'd10};
      end
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/radix_digit_converter_core.sv -----
// Top level of the radix digit converter: microcoded sequencer and datapath.
//
// A request is taken when start is high and busy is low; in_value is then
// converted to the base held in the radix register (index 0, byte address 0,
// written over the APB-style port; values below 2 act as 2, above 16 as 16).
// Each value is divided by the base one quotient bit per cycle, and every
// remainder is pushed onto a digit stack. The stack is then popped and each
// digit appears as an ASCII character on out_digit_char for one cycle with
// out_strobe high, most significant first; out_last_digit marks the final one.
// A value of zero produces no digits. Digits beyond STACK_DEPTH are dropped.
// The quotient is formed by a bit-serial divider loop, and no two digit
// strobes come back to back. Busy stays high until the last digit is shown.
// The receiver cannot stall the output. Reset clears the sequencer, the
// stack count and the output strobe, and sets the radix to 10.
`default_nettype none

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 31,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_strobe,
  output logic      [6:0]            out_digit_char,
  output logic                       out_last_digit
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int BW = $clog2(VALUE_BITS);
  localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  logic [4:0] radix_r;
  logic [4:0] base;
  step_t pc_r;
  step_t pc_nxt;
  ctrl_t cw;
  logic jump;
  logic [VALUE_BITS-1:0] q_r;
  logic [4:0] rem_r;
  logic [4:0] rem_sh;
  logic rem_ge;
  logic [BW-1:0] bit_r;
  logic [CW-1:0] cnt_r;
  logic [3:0] stack_mem [STACK_DEPTH];
  logic [3:0] rd_data_r;
  logic do_pop;
  logic do_push;
  logic out_strobe_r;
  logic [6:0] out_char_r;
  logic out_last_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIX) ? {27'd0, radix_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
      radix_r <= pwdata[4:0];
    end
  end

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  assign cw = ucode(pc_r);
  assign busy = (pc_r != STEP_IDLE);

  always_comb begin
    case (cw.cond)
      JMP_NEVER: jump = 1'b0;
      JMP_ALWAYS: jump = 1'b1;
      JMP_NO_START: jump = !start;
      JMP_Q_ZERO: jump = (q_r == '0);
      JMP_BITS_LEFT: jump = (bit_r != BIT_LAST);
      JMP_EMPTY: jump = (cnt_r == '0);
      default: jump = 1'b1;
    endcase
    pc_nxt = jump ? cw.target : step_t'(pc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign rem_sh = {rem_r[3:0], q_r[VALUE_BITS-1]};
  assign rem_ge = (rem_sh >= base);
  assign do_pop = (cw.op == OP_POP) && (cnt_r != '0);
  assign do_push = (cw.op == OP_PUSH) && (cnt_r < CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if ((cw.op == OP_LOAD) && start) begin
      cnt_r <= '0;
    end else if (do_push) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (do_pop) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (start) begin
          q_r <= in_value;
        end
      end
      OP_CLRDIV: begin
        rem_r <= '0;
        bit_r <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_ge ? (rem_sh - base) : rem_sh;
        q_r <= {q_r[VALUE_BITS-2:0], rem_ge};
        bit_r <= bit_r + BW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[cnt_r[AW-1:0]] <= rem_r[3:0];
    end
    if (do_pop) begin
      rd_data_r <= stack_mem[AW'(cnt_r - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cw.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT) begin
      out_char_r <= digit_ascii(rd_data_r);
      out_last_r <= (cnt_r == '0);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

`default_nettype wire

// ----- sv/rdc_checker.sv -----
// Port-level checker of the radix digit converter and its bind statement.
`default_nettype none
`include "radix_digit_converter_core_defines.svh"

module rdc_checker
  import rdc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [6:0] out_digit_char,
  input wire logic       out_last_digit
);

  logic char_ok;

  assign char_ok = ((out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_ZERO + 7'd9)) ||
                   ((out_digit_char >= CHAR_A) && (out_digit_char <= CHAR_A + 7'd5));

  `RDC_ASSERT_NEXT(a_busy_after_request, start && !busy, busy)
  `RDC_ASSERT_IMPL(a_char_is_digit, out_strobe, char_ok)
  `RDC_ASSERT_NEXT(a_strobe_spaced, out_strobe, !out_strobe)
  `RDC_ASSERT_NEXT(a_idle_after_last, out_strobe && out_last_digit, !busy)

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (.*);

`default_nettype wire
